>>> rtl/gis_pkg.sv
package gis_pkg;

   localparam int DEF_MAX_SRC_WIDTH  = 256;
   localparam int DEF_MAX_SRC_HEIGHT = 256;
   localparam int DEF_SCREEN_WIDTH   = 240;
   localparam int DEF_SCREEN_HEIGHT  = 135;

   localparam logic [15:0] RED_MASK   = 16'h001f;
   localparam logic [15:0] GREEN_MASK = 16'h003f;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 9;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_ORIGIN_X   = 3'd4,
      CSR_ORIGIN_Y   = 3'd5,
      CSR_THRESHOLD  = 3'd6
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_RENDER = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] src_row;
      logic [7:0] src_col;
      logic [7:0] gray_value;
      logic [7:0] dst_col;
      logic [7:0] dst_row;
   } req_item_type;

   typedef struct packed {
      logic [8:0]  screen_x;
      logic [8:0]  screen_y;
      logic [15:0] pixel_color;
      logic        on_screen;
   } rsp_item_type;

   function automatic logic [15:0] to_color(input logic [7:0] v, input logic [7:0] thr);
      logic [15:0] c;
      logic [15:0] v16;
      v16 = {8'd0, v};
      if (thr == 8'd0) begin
         c = (((v16 >> 3) & RED_MASK) << 11) | (((v16 >> 2) & GREEN_MASK) << 5)
             | ((v16 >> 3) & RED_MASK);
      end else begin
         c = (v < thr) ? 16'h0000 : 16'hffff;
      end
      return c;
   endfunction

endpackage

>>> rtl/gray_image_scaler_to_rgb565_unit.sv
// channel  direction  handshake          payload
// req      in         req_valid/stall    req_item_type
// rsp      out        rsp_valid/stall    rsp_item_type
// csr      in         csr_valid/ready    csr_index, csr_data
// one item per cycle while the output is not stalled; a render result passes through
// the product register, the 17-stage divider, then index, ram and color registers
// reset is synchronous; it clears valid bits and the csr registers, not the data registers or the ram
// a stalled result freezes the whole pipeline; load items write the ram and give no item
module gray_image_scaler_to_rgb565_unit
   import gis_pkg::*;
   #(parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
     parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
     parameter int SCREEN_WIDTH   = DEF_SCREEN_WIDTH,
     parameter int SCREEN_HEIGHT  = DEF_SCREEN_HEIGHT)
   (input  logic                       clock,
    input  logic                       reset,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  req_item_type               req_item,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output rsp_item_type               rsp_item,
    input  logic                       csr_valid,
    output logic                       csr_ready,
    input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
    input  logic [CSR_DATA_WIDTH-1:0]  csr_data);

   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = 17;
   localparam int DW    = 8;

   typedef struct packed {
      logic        valid;
      logic        is_load;
      logic        load_ok;
      logic [AW-1:0] load_addr;
      logic [7:0]  gray;
      logic [8:0]  sx;
      logic [8:0]  sy;
      logic        on_screen;
   } side_type;

   logic [8:0] src_width_ff, src_height_ff;
   logic [7:0] dst_width_ff, dst_height_ff, origin_x_ff, origin_y_ff, threshold_ff;

   logic     adv;
   side_type side_in;
   side_type side_ff [NW+1];
   logic [NW-1:0] ncol_ff, nrow_ff, qcol, qrow;

   side_type      s2_ff;
   logic [AW-1:0] s2_addr_ff;
   side_type      s3_ff;
   logic [7:0]    ram_data;

   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd188;
         src_height_ff <= 9'd120;
         dst_width_ff  <= 8'd188;
         dst_height_ff <= 8'd120;
         origin_x_ff   <= 8'd0;
         origin_y_ff   <= 8'd0;
         threshold_ff  <= 8'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data[7:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_data[7:0];
            CSR_ORIGIN_X:   origin_x_ff   <= csr_data[7:0];
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_data[7:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // product stage
   always_comb begin
      side_in.valid     = req_valid;
      side_in.is_load   = (req_item.req_type == REQ_LOAD);
      side_in.load_ok   = (32'(req_item.src_row) < MAX_SRC_HEIGHT)
                          && (32'(req_item.src_col) < MAX_SRC_WIDTH);
      side_in.load_addr = AW'(32'(req_item.src_row) * MAX_SRC_WIDTH + 32'(req_item.src_col));
      side_in.gray      = req_item.gray_value;
      side_in.sx        = {1'b0, origin_x_ff} + {1'b0, req_item.dst_col};
      side_in.sy        = {1'b0, origin_y_ff} + {1'b0, req_item.dst_row};
      side_in.on_screen = (32'(side_in.sx) < SCREEN_WIDTH) && (32'(side_in.sy) < SCREEN_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NW; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i <= NW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ncol_ff <= NW'({9'd0, req_item.dst_col} * src_width_ff);
         nrow_ff <= NW'({9'd0, req_item.dst_row} * src_height_ff);
      end
   end

   gis_div #(.NW(NW), .DW(DW)) u_div_col
      (.clock(clock), .en(adv), .num(ncol_ff), .den(dst_width_ff), .quo(qcol));

   gis_div #(.NW(NW), .DW(DW)) u_div_row
      (.clock(clock), .en(adv), .num(nrow_ff), .den(dst_height_ff), .quo(qrow));

   // index saturation and address
   logic [NW-1:0] lim_col, lim_row, sc, sr;

   always_comb begin
      lim_col = (32'(src_width_ff) < MAX_SRC_WIDTH) ? NW'(src_width_ff) : NW'(MAX_SRC_WIDTH);
      lim_row = (32'(src_height_ff) < MAX_SRC_HEIGHT) ? NW'(src_height_ff) : NW'(MAX_SRC_HEIGHT);
      if (dst_width_ff == 8'd0 || lim_col == '0) begin
         sc = '0;
      end else if (qcol > lim_col - NW'(1)) begin
         sc = lim_col - NW'(1);
      end else begin
         sc = qcol;
      end
      if (dst_height_ff == 8'd0 || lim_row == '0) begin
         sr = '0;
      end else if (qrow > lim_row - NW'(1)) begin
         sr = lim_row - NW'(1);
      end else begin
         sr = qrow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s2_ff <= side_ff[NW];
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_addr_ff <= side_ff[NW].is_load ? side_ff[NW].load_addr
                       : AW'(32'(sr) * MAX_SRC_WIDTH + 32'(sc));
      end
   end

   gis_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram
      (.clock(clock),
       .wr_en(adv && s2_ff.valid && s2_ff.is_load && s2_ff.load_ok),
       .wr_addr(s2_addr_ff),
       .wr_data(s2_ff.gray),
       .rd_en(adv),
       .rd_addr(s2_addr_ff),
       .rd_data(ram_data));

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_ff.valid && !s3_ff.is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_item_ff.screen_x    <= s3_ff.sx;
         rsp_item_ff.screen_y    <= s3_ff.sy;
         rsp_item_ff.pixel_color <= to_color(ram_data, threshold_ff);
         rsp_item_ff.on_screen   <= s3_ff.on_screen;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/gis_ram.sv
module gis_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 65536)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gis_div.sv
module gis_div
   #(parameter int NW = 17,
     parameter int DW = 8)
   (input  logic          clock,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo);

   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [DW-1:0] rem_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_step
      logic [NW-1:0] num_p;
      logic [NW-1:0] quo_p;
      logic [DW-1:0] rem_p;
      logic [DW:0]   t;
      logic          ge;
      if (i == 0) begin : g_first
         assign num_p = num;
         assign quo_p = '0;
         assign rem_p = '0;
      end else begin : g_next
         assign num_p = num_ff[i-1];
         assign quo_p = quo_ff[i-1];
         assign rem_p = rem_ff[i-1];
      end
      assign t  = {rem_p, num_p[NW-1-i]};
      assign ge = (t >= {1'b0, den});
      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= num_p;
            quo_ff[i] <= {quo_p[NW-2:0], ge};
            rem_ff[i] <= ge ? DW'(t - {1'b0, den}) : t[DW-1:0];
         end
      end
   end

   assign quo = quo_ff[NW-1];

endmodule

>>> rtl/gis_checker.sv
module gis_checker
   import gis_pkg::*;
   #(parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
     parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT)
   (input logic         clock,
    input logic         reset,
    input logic         req_stall,
    input logic         rsp_valid,
    input logic         rsp_stall,
    input rsp_item_type rsp_item,
    input logic         csr_ready);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");

   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.on_screen == ((32'(rsp_item.screen_x) < SCREEN_WIDTH)
                    && (32'(rsp_item.screen_y) < SCREEN_HEIGHT)))
      else $error("on_screen flag wrong");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready && !req_stall |-> !(rsp_valid && rsp_stall))
      else $error("csr or stall state wrong");

endmodule

bind gray_image_scaler_to_rgb565_unit gis_checker
   #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_gis_checker
   (.clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall), .rsp_item(rsp_item), .csr_ready(csr_ready));
